// ===== hdl/per_flow_packet_statistics_defines.svh =====
// Assertion macros for the checker in pfps_checker.sv.
`ifndef PER_FLOW_PACKET_STATISTICS_DEFINES_SVH
`define PER_FLOW_PACKET_STATISTICS_DEFINES_SVH
`define PFPS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
`define PFPS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// ===== hdl/pfps_pkg.sv =====
`timescale 1ns / 1ps
package pfps_pkg;
  localparam int unsigned AddrW = 64;
  localparam int unsigned SeqW = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned CntW = 32;
  localparam int unsigned StatW = 3;
  localparam int unsigned SlotW = 6;

  localparam logic [StatW-1:0] StFirst = 3'd0;
  localparam logic [StatW-1:0] StInOrder = 3'd1;
  localparam logic [StatW-1:0] StDup = 3'd2;
  localparam logic [StatW-1:0] StUnordered = 3'd3;
  localparam logic [StatW-1:0] StFull = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_WAIT, S_UPDATE, S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic search_start;
    logic search_step;
    logic update;
    logic full;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic at_end;
    logic table_full;
  } sts_t;
endpackage

// ===== hdl/pfps_ctrl.sv =====
`timescale 1ns / 1ps
module pfps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pfps_pkg::sts_t sts_i,
  output pfps_pkg::cmd_t cmd_o
);
  import pfps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SEARCH;
      S_SEARCH: begin
        if (sts_i.at_end) begin
          state_d = S_UPDATE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.hit || sts_i.at_end) begin
          state_d = S_UPDATE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_UPDATE: state_d = S_OUT;
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SEARCH: cmd_o.search_start = 1'b1;
      S_WAIT: cmd_o.search_step = !(sts_i.hit || sts_i.at_end);
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        cmd_o.full = sts_i.table_full;
      end
      S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hdl/pfps_datapath.sv =====
`timescale 1ns / 1ps
module pfps_datapath #(
  parameter int unsigned FLOW_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfps_pkg::cmd_t                 cmd_i,
  output pfps_pkg::sts_t                 sts_o,
  input  logic [pfps_pkg::AddrW-1:0]     src_addr_hi_i,
  input  logic [pfps_pkg::AddrW-1:0]     src_addr_lo_i,
  input  logic [pfps_pkg::SeqW-1:0]      seq_num_i,
  input  logic [pfps_pkg::TimeW-1:0]     send_time_us_i,
  input  logic [pfps_pkg::TimeW-1:0]     recv_time_us_i,
  output logic [pfps_pkg::StatW-1:0]     status_o,
  output logic [pfps_pkg::SlotW-1:0]     flow_slot_o,
  output logic [pfps_pkg::TimeW-1:0]     pkt_latency_o,
  output logic [pfps_pkg::TimeW-1:0]     min_latency_o,
  output logic [pfps_pkg::TimeW-1:0]     max_latency_o,
  output logic [pfps_pkg::CntW-1:0]      recv_count_o,
  output logic [pfps_pkg::CntW-1:0]      dup_count_o,
  output logic [pfps_pkg::CntW-1:0]      unordered_count_o,
  output logic [pfps_pkg::SeqW-1:0]      last_seq_o,
  output logic [pfps_pkg::CntW-1:0]      total_sent_o,
  output logic [pfps_pkg::CntW-1:0]      total_recvd_o,
  output logic [pfps_pkg::CntW-1:0]      total_dup_o
);
  import pfps_pkg::*;

  localparam int unsigned IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned EntW = 2 * AddrW;
  localparam int unsigned StatEntW = 4 * CntW + 2 * TimeW;
  localparam logic [FillW-1:0] FillMax = FillW'(FLOW_ENTRIES);

  logic [EntW-1:0]     addr_mem [FLOW_ENTRIES];
  logic [StatEntW-1:0] stat_mem [FLOW_ENTRIES];

  logic [AddrW-1:0] hi_q, lo_q;
  logic [SeqW-1:0]  seq_q;
  logic [TimeW-1:0] lat_q;
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] ptr_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [EntW-1:0]  addr_rd_q;
  logic [StatEntW-1:0] stat_rd_q;
  logic [CntW-1:0]  sum_seq_q, sum_recv_q, sum_dup_q;

  logic hit;
  assign hit = rd_vld_q && (addr_rd_q == {hi_q, lo_q});
  assign sts_o.hit = hit;
  assign sts_o.at_end = (ptr_q >= fill_q) && !rd_vld_q;
  assign sts_o.table_full = !hit && (fill_q == FillMax);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hi_q <= src_addr_hi_i;
      lo_q <= src_addr_lo_i;
      seq_q <= seq_num_i;
      lat_q <= (recv_time_us_i > send_time_us_i) ? recv_time_us_i - send_time_us_i : '0;
    end
  end

  logic rd_en;
  assign rd_en = (cmd_i.search_start || cmd_i.search_step) && (ptr_q < fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.search_start || cmd_i.search_step) begin
        rd_vld_q <= rd_en;
        if (rd_en) ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= ptr_q[IdxW-1:0];
      addr_rd_q <= addr_mem[ptr_q[IdxW-1:0]];
      stat_rd_q <= stat_mem[ptr_q[IdxW-1:0]];
    end
  end

  logic [CntW-1:0]  o_seq, o_recv, o_dup, o_uno;
  logic [TimeW-1:0] o_min, o_max;
  logic [CntW-1:0]  n_seq, n_recv, n_dup, n_uno;
  logic [TimeW-1:0] n_min, n_max;
  logic [StatW-1:0] n_st;
  logic [IdxW-1:0]  slot;

  always_comb begin
    if (hit) begin
      {o_seq, o_recv, o_dup, o_uno, o_min, o_max} = stat_rd_q;
      slot = rd_idx_q;
    end else begin
      {o_seq, o_recv, o_dup, o_uno, o_min, o_max} = '0;
      slot = fill_q[IdxW-1:0];
    end
    n_seq = o_seq; n_recv = o_recv; n_dup = o_dup; n_uno = o_uno;
    n_min = o_min; n_max = o_max;
    if (o_seq == '0) begin
      n_seq = seq_q;
      n_recv = o_recv + 1'b1;
      n_min = lat_q;
      n_max = lat_q;
      n_st = StFirst;
    end else begin
      if (seq_q == o_seq) begin
        n_dup = o_dup + 1'b1;
        n_st = StDup;
      end else if (seq_q < o_seq) begin
        n_uno = o_uno + 1'b1;
        n_recv = o_recv + 1'b1;
        n_st = StUnordered;
      end else begin
        n_seq = seq_q;
        n_recv = o_recv + 1'b1;
        n_st = StInOrder;
      end
      if (lat_q < o_min) n_min = lat_q;
      if (lat_q > o_max) n_max = lat_q;
    end
  end

  logic [CntW-1:0] rm_seq, rm_recv, rm_dup, ad_seq, ad_recv, ad_dup;
  always_comb begin
    rm_seq = (o_recv != '0) ? o_seq : '0;
    rm_recv = o_recv;
    rm_dup = (o_recv != '0) ? o_dup : '0;
    ad_seq = (n_recv != '0) ? n_seq : '0;
    ad_recv = n_recv;
    ad_dup = (n_recv != '0) ? n_dup : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !cmd_i.full) begin
      addr_mem[slot] <= {hi_q, lo_q};
      stat_mem[slot] <= {n_seq, n_recv, n_dup, n_uno, n_min, n_max};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_seq_q <= '0;
      sum_recv_q <= '0;
      sum_dup_q <= '0;
    end else if (cmd_i.update && !cmd_i.full) begin
      if (!hit) fill_q <= fill_q + 1'b1;
      sum_seq_q <= sum_seq_q - rm_seq + ad_seq;
      sum_recv_q <= sum_recv_q - rm_recv + ad_recv;
      sum_dup_q <= sum_dup_q - rm_dup + ad_dup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      pkt_latency_o <= lat_q;
      if (cmd_i.full) begin
        status_o <= StFull;
        flow_slot_o <= '0;
        min_latency_o <= '0;
        max_latency_o <= '0;
        recv_count_o <= '0;
        dup_count_o <= '0;
        unordered_count_o <= '0;
        last_seq_o <= '0;
        total_sent_o <= sum_seq_q;
        total_recvd_o <= sum_recv_q;
        total_dup_o <= sum_dup_q;
      end else begin
        status_o <= n_st;
        flow_slot_o <= SlotW'(32'(slot));
        min_latency_o <= n_min;
        max_latency_o <= n_max;
        recv_count_o <= n_recv;
        dup_count_o <= n_dup;
        unordered_count_o <= n_uno;
        last_seq_o <= n_seq;
        total_sent_o <= sum_seq_q - rm_seq + ad_seq;
        total_recvd_o <= sum_recv_q - rm_recv + ad_recv;
        total_dup_o <= sum_dup_q - rm_dup + ad_dup;
      end
    end
  end
endmodule

// ===== hdl/per_flow_packet_statistics.sv =====
`timescale 1ns / 1ps
// Channel | Signals                         | Direction
// in      | in_valid_i, in_stall_o, fields  | packet item into the block
// out     | out_valid_o, out_stall_i, fields| result item out of the block
// Each item is handled by a linear search that reads one table entry per cycle over the N
// flows in use; with no hit it runs to the end of the table, and a hit at slot j ends the
// search early.
// Reset clears the fill count and the totals; table contents need no clearing.
// The block takes a new item only after the previous result has been taken, so output
// stall delays the acceptance of the next item.
module per_flow_packet_statistics #(
  parameter int unsigned FLOW_ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pfps_pkg::AddrW-1:0] src_addr_hi_i,
  input  logic [pfps_pkg::AddrW-1:0] src_addr_lo_i,
  input  logic [pfps_pkg::SeqW-1:0]  seq_num_i,
  input  logic [pfps_pkg::TimeW-1:0] send_time_us_i,
  input  logic [pfps_pkg::TimeW-1:0] recv_time_us_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pfps_pkg::StatW-1:0] status_o,
  output logic [pfps_pkg::SlotW-1:0] flow_slot_o,
  output logic [pfps_pkg::TimeW-1:0] pkt_latency_o,
  output logic [pfps_pkg::TimeW-1:0] min_latency_o,
  output logic [pfps_pkg::TimeW-1:0] max_latency_o,
  output logic [pfps_pkg::CntW-1:0]  recv_count_o,
  output logic [pfps_pkg::CntW-1:0]  dup_count_o,
  output logic [pfps_pkg::CntW-1:0]  unordered_count_o,
  output logic [pfps_pkg::SeqW-1:0]  last_seq_o,
  output logic [pfps_pkg::CntW-1:0]  total_sent_o,
  output logic [pfps_pkg::CntW-1:0]  total_recvd_o,
  output logic [pfps_pkg::CntW-1:0]  total_dup_o
);
  import pfps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pfps_datapath #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .src_addr_hi_i, .src_addr_lo_i, .seq_num_i, .send_time_us_i, .recv_time_us_i,
    .status_o, .flow_slot_o, .pkt_latency_o, .min_latency_o, .max_latency_o,
    .recv_count_o, .dup_count_o, .unordered_count_o, .last_seq_o,
    .total_sent_o, .total_recvd_o, .total_dup_o
  );
endmodule

// ===== hdl/pfps_checker.sv =====
`timescale 1ns / 1ps
`include "per_flow_packet_statistics_defines.svh"
module pfps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [5:0] flow_slot_o
);
  import pfps_pkg::*;

  `PFPS_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid_o, in_stall_o)
  `PFPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `PFPS_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= StFull)
  `PFPS_ASSERT_IMP(a_full_slot, clk_i, rst_ni, out_valid_o && status_o == StFull, flow_slot_o == '0)
  `PFPS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !out_valid_o)
endmodule

bind per_flow_packet_statistics pfps_checker u_pfps_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .flow_slot_o
);

// ===== test/per_flow_packet_statistics_checker.sv =====
`timescale 1ns / 1ps
module per_flow_packet_statistics_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [pfps_pkg::AddrW-1:0] src_addr_hi_i,
  input  logic [pfps_pkg::AddrW-1:0] src_addr_lo_i,
  input  logic [pfps_pkg::SeqW-1:0]  seq_num_i,
  input  logic [pfps_pkg::TimeW-1:0] send_time_us_i,
  input  logic [pfps_pkg::TimeW-1:0] recv_time_us_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [pfps_pkg::StatW-1:0] status_i,
  input  logic [pfps_pkg::SlotW-1:0] flow_slot_i,
  input  logic [pfps_pkg::TimeW-1:0] pkt_latency_i,
  input  logic [pfps_pkg::TimeW-1:0] min_latency_i,
  input  logic [pfps_pkg::TimeW-1:0] max_latency_i,
  input  logic [pfps_pkg::CntW-1:0]  recv_count_i,
  input  logic [pfps_pkg::CntW-1:0]  dup_count_i,
  input  logic [pfps_pkg::CntW-1:0]  unordered_count_i,
  input  logic [pfps_pkg::SeqW-1:0]  last_seq_i,
  input  logic [pfps_pkg::CntW-1:0]  total_sent_i,
  input  logic [pfps_pkg::CntW-1:0]  total_recvd_i,
  input  logic [pfps_pkg::CntW-1:0]  total_dup_i,
  output int                         errors_o,
  output int                         pending_o
);
  import pfps_pkg::*;

  localparam int unsigned Flows = 64;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] lat;
    logic [TimeW-1:0] min_lat;
    logic [TimeW-1:0] max_lat;
    logic [CntW-1:0]  recvd;
    logic [CntW-1:0]  dups;
    logic [CntW-1:0]  unordered;
    logic [SeqW-1:0]  last;
    logic [CntW-1:0]  sum_sent;
    logic [CntW-1:0]  sum_recvd;
    logic [CntW-1:0]  sum_dup;
  } flow_report_t;

  logic [AddrW-1:0] tbl_hi [Flows];
  logic [AddrW-1:0] tbl_lo [Flows];
  logic [SeqW-1:0]  tbl_seq [Flows];
  logic [CntW-1:0]  tbl_recv [Flows];
  logic [CntW-1:0]  tbl_dup [Flows];
  logic [CntW-1:0]  tbl_unord [Flows];
  logic [TimeW-1:0] tbl_min [Flows];
  logic [TimeW-1:0] tbl_max [Flows];
  int unsigned      used;
  logic [CntW-1:0]  sum_sent, sum_recvd, sum_dup;
  flow_report_t     expected_reports[$];

  function automatic flow_report_t track_packet(logic [AddrW-1:0] hi, logic [AddrW-1:0] lo,
                                                logic [SeqW-1:0] seq, logic [TimeW-1:0] ts,
                                                logic [TimeW-1:0] tr);
    flow_report_t r;
    int s;
    logic hit;
    r = '0;
    r.lat = (tr > ts) ? tr - ts : '0;
    hit = 1'b0;
    s = 0;
    for (int i = 0; i < used; i++) begin
      if (!hit && tbl_hi[i] == hi && tbl_lo[i] == lo) begin
        hit = 1'b1;
        s = i;
      end
    end
    if (!hit) begin
      if (used >= Flows) begin
        r.status = StFull;
        r.sum_sent = sum_sent;
        r.sum_recvd = sum_recvd;
        r.sum_dup = sum_dup;
        return r;
      end
      s = used;
      used++;
      tbl_hi[s] = hi;
      tbl_lo[s] = lo;
      tbl_seq[s] = '0;
      tbl_recv[s] = '0;
      tbl_dup[s] = '0;
      tbl_unord[s] = '0;
      tbl_min[s] = '0;
      tbl_max[s] = '0;
    end
    if (tbl_recv[s] != 0) begin
      sum_sent -= tbl_seq[s];
      sum_recvd -= tbl_recv[s];
      sum_dup -= tbl_dup[s];
    end
    if (tbl_seq[s] == 0) begin
      tbl_seq[s] = seq;
      tbl_recv[s]++;
      tbl_min[s] = r.lat;
      tbl_max[s] = r.lat;
      r.status = StFirst;
    end else begin
      if (seq == tbl_seq[s]) begin
        tbl_dup[s]++;
        r.status = StDup;
      end else if (seq < tbl_seq[s]) begin
        tbl_unord[s]++;
        tbl_recv[s]++;
        r.status = StUnordered;
      end else begin
        tbl_seq[s] = seq;
        tbl_recv[s]++;
        r.status = StInOrder;
      end
      if (r.lat < tbl_min[s]) tbl_min[s] = r.lat;
      if (r.lat > tbl_max[s]) tbl_max[s] = r.lat;
    end
    if (tbl_recv[s] != 0) begin
      sum_sent += tbl_seq[s];
      sum_recvd += tbl_recv[s];
      sum_dup += tbl_dup[s];
    end
    r.slot = s[SlotW-1:0];
    r.min_lat = tbl_min[s];
    r.max_lat = tbl_max[s];
    r.recvd = tbl_recv[s];
    r.dups = tbl_dup[s];
    r.unordered = tbl_unord[s];
    r.last = tbl_seq[s];
    r.sum_sent = sum_sent;
    r.sum_recvd = sum_recvd;
    r.sum_dup = sum_dup;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    flow_report_t e;
    if (!rst_ni) begin
      errors_o = 0;
      used = 0;
      sum_sent = '0;
      sum_recvd = '0;
      sum_dup = '0;
      expected_reports.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result item with none expected", $realtime);
          errors_o++;
        end else begin
          e = expected_reports.pop_front();
          if (status_i !== e.status) report_mismatch("status", status_i, e.status);
          if (flow_slot_i !== e.slot) report_mismatch("flow_slot", flow_slot_i, e.slot);
          if (pkt_latency_i !== e.lat) report_mismatch("pkt_latency", pkt_latency_i, e.lat);
          if (min_latency_i !== e.min_lat)
            report_mismatch("min_latency", min_latency_i, e.min_lat);
          if (max_latency_i !== e.max_lat)
            report_mismatch("max_latency", max_latency_i, e.max_lat);
          if (recv_count_i !== e.recvd) report_mismatch("recv_count", recv_count_i, e.recvd);
          if (dup_count_i !== e.dups) report_mismatch("dup_count", dup_count_i, e.dups);
          if (unordered_count_i !== e.unordered)
            report_mismatch("unordered_count", unordered_count_i, e.unordered);
          if (last_seq_i !== e.last) report_mismatch("last_seq", last_seq_i, e.last);
          if (total_sent_i !== e.sum_sent)
            report_mismatch("total_sent", total_sent_i, e.sum_sent);
          if (total_recvd_i !== e.sum_recvd)
            report_mismatch("total_recvd", total_recvd_i, e.sum_recvd);
          if (total_dup_i !== e.sum_dup) report_mismatch("total_dup", total_dup_i, e.sum_dup);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_reports.push_back(track_packet(src_addr_hi_i, src_addr_lo_i, seq_num_i,
                                                send_time_us_i, recv_time_us_i));
      end
      pending_o = expected_reports.size();
    end
  end
endmodule

// ===== test/per_flow_packet_statistics_test.sv =====
`timescale 1ns / 1ps
module per_flow_packet_statistics_test;
  import pfps_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [AddrW-1:0] src_addr_hi_i = '0;
  logic [AddrW-1:0] src_addr_lo_i = '0;
  logic [SeqW-1:0]  seq_num_i = '0;
  logic [TimeW-1:0] send_time_us_i = '0;
  logic [TimeW-1:0] recv_time_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic [SlotW-1:0] flow_slot_o;
  logic [TimeW-1:0] pkt_latency_o, min_latency_o, max_latency_o;
  logic [CntW-1:0]  recv_count_o, dup_count_o, unordered_count_o;
  logic [SeqW-1:0]  last_seq_o;
  logic [CntW-1:0]  total_sent_o, total_recvd_o, total_dup_o;
  int errors, pending, idle_cycles;
  bit quiet, long_hold;
  logic [AddrW-1:0] pool_hi [16];
  logic [AddrW-1:0] pool_lo [16];
  logic [SeqW-1:0]  pool_seq [16];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  per_flow_packet_statistics i_dut (.*);

  per_flow_packet_statistics_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .src_addr_hi_i, .src_addr_lo_i,
    .seq_num_i, .send_time_us_i, .recv_time_us_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .flow_slot_i(flow_slot_o), .pkt_latency_i(pkt_latency_o),
    .min_latency_i(min_latency_o), .max_latency_i(max_latency_o),
    .recv_count_i(recv_count_o), .dup_count_i(dup_count_o),
    .unordered_count_i(unordered_count_o), .last_seq_i(last_seq_o),
    .total_sent_i(total_sent_o), .total_recvd_i(total_recvd_o), .total_dup_i(total_dup_o),
    .errors_o(errors), .pending_o(pending)
  );

  task automatic send_packet(logic [AddrW-1:0] hi, logic [AddrW-1:0] lo, logic [SeqW-1:0] seq,
                             logic [TimeW-1:0] ts, logic [TimeW-1:0] tr);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(14, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_addr_hi_i <= hi;
    src_addr_lo_i <= lo;
    seq_num_i <= seq;
    send_time_us_i <= ts;
    recv_time_us_i <= tr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  always @(posedge clk_i) begin
    int n;
    if (long_hold) begin
      out_stall_i <= 1'b1;
      repeat (400) @(posedge clk_i);
      out_stall_i <= 1'b0;
      long_hold = 1'b0;
    end else if (!quiet && $urandom_range(5) == 0) begin
      n = $urandom_range(14, 1);
      out_stall_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [47:0] t;
    int k;
    idle_cycles = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_packet('0, '0, 32'd0, 48'd10, 48'd5);
    send_packet('0, '0, 32'd0, 48'd5, 48'd10);
    send_packet('0, '0, 32'd5, 48'd0, '1);
    send_packet('0, '0, 32'd5, 48'd0, 48'd3);
    send_packet('0, '0, 32'd2, '1, 48'd0);
    send_packet('0, '0, '1, 48'd1, 48'd2);
    send_packet('0, '0, '1, 48'd1, 48'd2);
    send_packet('1, '1, '1, '1, '1);
    send_packet('1, '1, 32'd1, '0, '1);
    send_packet('1, '0, 32'd7, 48'd100, 48'd50);
    send_packet('0, '1, 32'd9, 48'd100, 48'd150);
    send_packet('0, '1, 32'd10, 48'd100, 48'd110);
    // The receiver holds off while packets keep coming, so the block backs up.
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_packet('1, '1, $urandom(), rand48(), rand48());
    drain_results();
    for (int i = 0; i < 16; i++) begin
      pool_hi[i] = {$urandom(), $urandom()};
      pool_lo[i] = {$urandom(), $urandom()};
      pool_seq[i] = $urandom_range(3);
    end
    for (int i = 0; i < 400; i++) begin
      if (i == 340) begin
        drain_results();
        quiet = 1'b1;
      end
      k = $urandom_range(15);
      t = rand48();
      if (i >= 150 && i < 250) begin
        // Fill the table to capacity with fresh sources.
        send_packet({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), t,
                    t + $urandom_range(500));
      end else if ($urandom_range(7) == 0) begin
        send_packet({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), rand48(),
                    rand48());
      end else begin
        case ($urandom_range(5))
          0: pool_seq[k] = pool_seq[k];
          1: pool_seq[k] = pool_seq[k] - $urandom_range(3);
          default: pool_seq[k] = pool_seq[k] + $urandom_range(3, 1);
        endcase
        send_packet(pool_hi[k], pool_lo[k], pool_seq[k], t,
                    ($urandom_range(4) == 0) ? t - $urandom_range(50) : t + $urandom_range(900));
      end
    end
    drain_results();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pfps_pkg.sv
hdl/pfps_ctrl.sv
hdl/pfps_datapath.sv
hdl/per_flow_packet_statistics.sv
hdl/pfps_checker.sv
test/per_flow_packet_statistics_checker.sv
test/per_flow_packet_statistics_test.sv
